// File: sv/qpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared widths, payload types and the divider step for the quaternion
// point rotation pipeline.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int CW = 32;            // point coordinate width, Q16.16
    localparam int QW = 16;            // quaternion part width, Q1.14
    localparam int PW = CW + QW;       // v*p product
    localparam int UW = PW + 2;        // u = v x p + w*p
    localparam int TPW = UW + QW;      // v*u product
    localparam int TW = TPW + 1;       // t = v x u
    localparam int MW = TW + 1;        // 2t
    localparam int NW = 2 * QW + 1;    // n = w^2 + |v|^2
    localparam int DQ = CW + 3;        // quotient bits, |2t/n| <= 3|p| < 2^(CW+2)
    localparam int RW = DQ + 3;        // p +/- rounded quotient
    localparam int DIV_STEPS = DQ;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_QUAT_W = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_QUAT_X = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_QUAT_Y = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_QUAT_Z = 2'd3;

    localparam logic [QW-1:0] QUAT_ONE = {2'b01, {(QW-2){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } t_pt_in;

    typedef struct packed {
        logic signed [CW-1:0] rot_x;
        logic signed [CW-1:0] rot_y;
        logic signed [CW-1:0] rot_z;
        logic                 saturated;
        logic                 bad_quaternion;
    } t_pt_out;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } t_quat;

    // One divider stage: partial remainder plus a shift word that starts as the
    // low dividend bits and ends as the quotient.
    typedef struct packed {
        logic [2:0][NW-1:0] rem;
        logic [2:0][DQ-1:0] wq;
        logic [2:0]         neg;
        logic               bad;
        t_pt_in             pt;
    } t_div;

    function automatic t_div div_step(input t_div d, input logic [NW-1:0] n);
        t_div       r;
        logic [NW:0] trial;
        logic [NW:0] diff;
        logic        ge;
        r = d;
        for (int i = 0; i < 3; i++) begin
            trial = {d.rem[i], d.wq[i][DQ-1]};
            diff  = trial - {1'b0, n};
            ge    = (trial >= {1'b0, n});
            r.rem[i] = ge ? diff[NW-1:0] : trial[NW-1:0];
            r.wq[i]  = {d.wq[i][DQ-2:0], ge};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/qpr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_front
// Five-stage datapath: input capture, v x p and w*p products, u sum,
// v x u products, then 2t magnitude split into divider start words.
// ----------------------------------------------------------------------------
module qpr_front
    import qpr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_pt_in i_pt,
    input  wire t_quat  i_quat,
    output logic        o_valid,
    output t_div        o_div
);

    logic               r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    t_pt_in             r_a_pt, r_b_pt, r_c_pt, r_d_pt;
    t_div               r_e_div;

    logic signed [CW-1:0]  a_p  [3];
    logic signed [QW-1:0]  q_v  [3];

    logic signed [PW-1:0]  n_b_m1 [3];
    logic signed [PW-1:0]  n_b_m2 [3];
    logic signed [PW-1:0]  n_b_wp [3];
    logic signed [PW-1:0]  r_b_m1 [3];
    logic signed [PW-1:0]  r_b_m2 [3];
    logic signed [PW-1:0]  r_b_wp [3];

    logic signed [UW-1:0]  n_c_u [3];
    logic signed [UW-1:0]  r_c_u [3];

    logic signed [TPW-1:0] n_d_m1 [3];
    logic signed [TPW-1:0] n_d_m2 [3];
    logic signed [TPW-1:0] r_d_m1 [3];
    logic signed [TPW-1:0] r_d_m2 [3];

    logic signed [TW-1:0]  e_t   [3];
    logic        [MW-1:0]  e_dbl [3];
    logic        [MW-1:0]  e_mag [3];
    t_div                  n_e_div;

    assign a_p[0] = r_a_pt.point_x;
    assign a_p[1] = r_a_pt.point_y;
    assign a_p[2] = r_a_pt.point_z;
    assign q_v[0] = i_quat.x;
    assign q_v[1] = i_quat.y;
    assign q_v[2] = i_quat.z;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        assign n_b_m1[i] = q_v[J] * a_p[K];
        assign n_b_m2[i] = q_v[K] * a_p[J];
        assign n_b_wp[i] = i_quat.w * a_p[i];

        assign n_c_u[i] = $signed({{2{r_b_m1[i][PW-1]}}, r_b_m1[i]})
                        - $signed({{2{r_b_m2[i][PW-1]}}, r_b_m2[i]})
                        + $signed({{2{r_b_wp[i][PW-1]}}, r_b_wp[i]});

        assign n_d_m1[i] = q_v[J] * r_c_u[K];
        assign n_d_m2[i] = q_v[K] * r_c_u[J];

        assign e_t[i]   = $signed({r_d_m1[i][TPW-1], r_d_m1[i]})
                        - $signed({r_d_m2[i][TPW-1], r_d_m2[i]});
        assign e_dbl[i] = {e_t[i], 1'b0};
        assign e_mag[i] = e_dbl[i][MW-1] ? (~e_dbl[i] + 1'b1) : e_dbl[i];
    end

    always_comb begin
        n_e_div     = '0;
        n_e_div.pt  = r_d_pt;
        n_e_div.bad = (i_quat == '0);
        for (int i = 0; i < 3; i++) begin
            // |2t| < 2^DQ * n, so the top bits already sit below n
            n_e_div.rem[i] = e_mag[i][MW-1:DQ];
            n_e_div.wq[i]  = e_mag[i][DQ-1:0];
            n_e_div.neg[i] = e_dbl[i][MW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pt  <= i_pt;
            r_b_pt  <= r_a_pt;
            r_c_pt  <= r_b_pt;
            r_d_pt  <= r_c_pt;
            r_e_div <= n_e_div;
            for (int i = 0; i < 3; i++) begin
                r_b_m1[i] <= n_b_m1[i];
                r_b_m2[i] <= n_b_m2[i];
                r_b_wp[i] <= n_b_wp[i];
                r_c_u[i]  <= n_c_u[i];
                r_d_m1[i] <= n_d_m1[i];
                r_d_m2[i] <= n_d_m2[i];
            end
        end
    end

    assign o_valid = r_e_valid;
    assign o_div   = r_e_div;

endmodule
`default_nettype wire

// File: sv/qpr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_div
// Pipelined restoring divider, one quotient bit per stage for all three axes.
// ----------------------------------------------------------------------------
module qpr_div
    import qpr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_div          i_data,
    input  wire logic [NW-1:0] i_norm,
    output logic               o_valid,
    output t_div               o_data
);

    t_div r_stage [DIV_STEPS];
    t_div n_stage [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_vld;

    always_comb begin
        n_stage[0] = div_step(i_data, i_norm);
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_stage[k] = div_step(r_stage[k-1], i_norm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_data  = r_stage[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: sv/qpr_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpr_out
// Round-to-nearest stage, offset add with saturation, and the output
// register with a skid entry that holds the pipeline when full.
// ----------------------------------------------------------------------------
module qpr_out
    import qpr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_div          i_data,
    input  wire logic [NW-1:0] i_norm,
    input  wire logic          i_out_ready,
    output logic               o_en,
    output logic               o_out_valid,
    output t_pt_out            o_out_data
);

    localparam logic signed [RW-1:0] CMAX = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [RW-1:0] CMIN = ~CMAX;

    logic              en;
    logic              r_r_valid;
    logic [DQ:0]       r_r_quo [3];
    logic [2:0]        r_r_neg;
    logic              r_r_bad;
    t_pt_in            r_r_pt;
    logic [DQ:0]       n_r_quo [3];

    logic signed [CW-1:0] pv   [3];
    logic signed [RW-1:0] sum  [3];
    logic        [CW-1:0] rot  [3];
    logic        [2:0]    clip;
    t_pt_out              s_data;

    logic    r_out_valid, r_skid_valid;
    t_pt_out r_out_data, r_skid_data;
    logic    out_take;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // ties round away from zero: bump when 2*rem >= n
            n_r_quo[i] = {1'b0, i_data.wq[i]}
                       + {{DQ{1'b0}}, ({i_data.rem[i], 1'b0} >= {1'b0, i_norm})};
        end
    end

    assign pv[0] = r_r_pt.point_x;
    assign pv[1] = r_r_pt.point_y;
    assign pv[2] = r_r_pt.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = r_r_neg[i]
                   ? $signed({{(RW-CW){pv[i][CW-1]}}, pv[i]})
                     - $signed({{(RW-DQ-1){1'b0}}, r_r_quo[i]})
                   : $signed({{(RW-CW){pv[i][CW-1]}}, pv[i]})
                     + $signed({{(RW-DQ-1){1'b0}}, r_r_quo[i]});
            priority if (sum[i] > CMAX) begin
                rot[i]  = CMAX[CW-1:0];
                clip[i] = 1'b1;
            end else if (sum[i] < CMIN) begin
                rot[i]  = CMIN[CW-1:0];
                clip[i] = 1'b1;
            end else begin
                rot[i]  = sum[i][CW-1:0];
                clip[i] = 1'b0;
            end
        end
        if (r_r_bad) begin
            s_data.rot_x          = r_r_pt.point_x;
            s_data.rot_y          = r_r_pt.point_y;
            s_data.rot_z          = r_r_pt.point_z;
            s_data.saturated      = 1'b0;
            s_data.bad_quaternion = 1'b1;
        end else begin
            s_data.rot_x          = rot[0];
            s_data.rot_y          = rot[1];
            s_data.rot_z          = rot[2];
            s_data.saturated      = |clip;
            s_data.bad_quaternion = 1'b0;
        end
    end

    assign en       = !r_skid_valid;
    assign out_take = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (en) begin
            r_r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_neg <= i_data.neg;
            r_r_bad <= i_data.bad;
            r_r_pt  <= i_data.pt;
            for (int i = 0; i < 3; i++) begin
                r_r_quo[i] <= n_r_quo[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_r_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_r_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= s_data;
            end else begin
                r_skid_data <= s_data;
            end
        end
    end

    assign o_en        = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// File: sv/quaternion_point_rotation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 5 front stages, one divider stage per quotient bit (35), the round
// stage and the output register.
// Throughput: one transaction per cycle; the pipeline holds only while the
// output skid entry is full.
// Reset: clears all valid bits; quaternion returns to (1.0; 0, 0, 0).
// ----------------------------------------------------------------------------
// quaternion_point_rotation_unit
// Rotates a stream of Q16.16 points by the configured Q1.14 quaternion,
// p + 2(v x (v x p + w p))/n, rounded and saturated per axis.
// ----------------------------------------------------------------------------
module quaternion_point_rotation_unit
    import qpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [QW-1:0]     i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_pt_in            i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_pt_out                o_out_data
);

    t_quat             r_quat;
    logic [2*QW-1:0]   r_sq [4];
    logic [NW-1:0]     r_norm;
    logic signed [2*QW-1:0] sq [4];

    logic  en;
    logic  front_valid, div_valid;
    t_div  front_div, div_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= QUAT_ONE;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUAT_W: r_quat.w <= i_cfg_data;
                CFG_QUAT_X: r_quat.x <= i_cfg_data;
                CFG_QUAT_Y: r_quat.y <= i_cfg_data;
                CFG_QUAT_Z: r_quat.z <= i_cfg_data;
            endcase
        end
    end

    // norm follows the registers through r_sq and then r_norm after a write
    assign sq[0] = r_quat.w * r_quat.w;
    assign sq[1] = r_quat.x * r_quat.x;
    assign sq[2] = r_quat.y * r_quat.y;
    assign sq[3] = r_quat.z * r_quat.z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sq[i] <= sq[i];
        end
        r_norm <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]} + {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
    end

    qpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_pt    (i_in_data),
        .i_quat  (r_quat),
        .o_valid (front_valid),
        .o_div   (front_div)
    );

    qpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_data  (front_div),
        .i_norm  (r_norm),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    qpr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .i_data      (div_data),
        .i_norm      (r_norm),
        .i_out_ready (i_out_ready),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = en;

    // a held pipeline means a result is waiting at the output
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("pipeline held without a pending output transaction");

    a_bad_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_quaternion) |-> !o_out_data.saturated)
        else $error("pass-through result flagged as saturated");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output valid or input stall right after reset");

endmodule
`default_nettype wire
